>>> hw/rtl/lcld_pkg.sv
// shared types and character codes for the led command line decoder
// no dependencies

package lcld_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0] SUB_AUX     = 4'd8;
    localparam logic [3:0] SUB_NINE    = 4'd9;
    localparam logic [2:0] CHAN_NINE   = 3'd6;
    localparam logic [2:0] CHAN_TOP    = 3'd7;

    localparam logic [1:0] PH_BEFORE = 2'd0;
    localparam logic [1:0] PH_NUMBER = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam int         MAG_W      = 20;
    localparam int         LEVEL_W    = 12;
    localparam logic [MAG_W-1:0]   MAG_MAX    = 20'hfffff;
    localparam logic [MAG_W-1:0]   AUX_MAX    = 20'd255;
    localparam logic [MAG_W-1:0]   HALF_MAX   = 20'd2047;
    localparam logic [LEVEL_W-1:0] DRIVER_MAX = 12'd4095;

    typedef struct packed {
        logic               valid;
        logic               to_aux;
        logic [2:0]         chan;
        logic [LEVEL_W-1:0] level;
    } cmd_t;

endpackage

>>> hw/rtl/lcld_line.sv
// line assembly state, running number parse and line-end command decode
// depends on lcld_pkg

module lcld_line #(
    parameter int LINE_MAX = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic [7:0]    rx_byte,
    output lcld_pkg::cmd_t cmd
);
    import lcld_pkg::*;

    localparam int POS_W = $clog2(LINE_MAX);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(LINE_MAX - 1);
    localparam logic [POS_W-1:0] POS_ZERO  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_THREE = POS_W'(3);

    logic [POS_W-1:0] pos_reg,    pos_next;
    logic [7:0]       first_reg,  first_next;
    logic [7:0]       second_reg, second_next;
    logic [1:0]       phase_reg,  phase_next;
    logic             neg_reg,    neg_next;
    logic [MAG_W-1:0] mag_reg,    mag_next;

    logic             is_end;
    logic             is_cr;
    logic             is_dig;
    logic             is_ws;
    logic [MAG_W+3:0] mag_sum;
    logic [MAG_W-1:0] mag_add;
    logic [3:0]       sub;
    logic             sub_ok;
    logic             target_ok;
    logic [MAG_W-1:0] lvl;
    logic [LEVEL_W-1:0] aux_lvl;
    logic [LEVEL_W-1:0] drv_lvl;

    assign is_end = (rx_byte == CH_NUL) || (rx_byte == CH_LF);
    assign is_cr  = (rx_byte == CH_CR);
    assign is_dig = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_ws  = (rx_byte == CH_SP) || (rx_byte == CH_TAB) ||
                    (rx_byte == CH_VT) || (rx_byte == CH_FF);

    // times ten plus digit, saturating
    assign mag_sum = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1) +
                     {{(MAG_W){1'b0}}, rx_byte[3:0]};
    assign mag_add = (mag_sum > {4'b0, MAG_MAX}) ? MAG_MAX : mag_sum[MAG_W-1:0];

    always_comb
    begin
        pos_next    = pos_reg;
        first_next  = first_reg;
        second_next = second_reg;
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        if (fire)
        begin
            if (is_end)
            begin
                pos_next    = POS_ZERO;
                first_next  = CH_NUL;
                second_next = CH_NUL;
                phase_next  = PH_BEFORE;
                neg_next    = 1'b0;
                mag_next    = '0;
            end
            else if (!is_cr && (pos_reg < POS_LAST))
            begin
                pos_next = pos_reg + POS_ONE;
                if (pos_reg == POS_ZERO)
                begin
                    first_next = rx_byte;
                end
                else if (pos_reg == POS_ONE)
                begin
                    second_next = rx_byte;
                end
                else if (pos_reg >= POS_THREE)
                begin
                    case (phase_reg)
                        PH_BEFORE:
                        begin
                            if (rx_byte == CH_PLUS)
                            begin
                                phase_next = PH_NUMBER;
                            end
                            else if (rx_byte == CH_MINUS)
                            begin
                                neg_next   = 1'b1;
                                phase_next = PH_NUMBER;
                            end
                            else if (is_dig)
                            begin
                                mag_next   = mag_add;
                                phase_next = PH_NUMBER;
                            end
                            else if (!is_ws)
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        PH_NUMBER:
                        begin
                            if (is_dig)
                            begin
                                mag_next = mag_add;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_ZERO;
            first_reg  <= CH_NUL;
            second_reg <= CH_NUL;
            phase_reg  <= PH_BEFORE;
            neg_reg    <= 1'b0;
            mag_reg    <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            mag_reg    <= mag_next;
        end
    end

    // line-end decode
    assign sub       = second_reg[3:0];
    assign sub_ok    = (second_reg >= CH_ZERO) && (second_reg <= CH_NINE);
    assign target_ok = (first_reg == CH_EIGHT) ||
                       ((first_reg == CH_NINE) && (sub != SUB_NINE));
    assign lvl       = neg_reg ? '0 : mag_reg;
    assign aux_lvl   = (lvl > AUX_MAX) ? AUX_MAX[LEVEL_W-1:0] : lvl[LEVEL_W-1:0];
    assign drv_lvl   = (lvl > HALF_MAX) ? DRIVER_MAX : {lvl[LEVEL_W-2:0], 1'b0};

    always_comb
    begin
        cmd.valid  = fire && is_end && (pos_reg >= POS_THREE) && sub_ok && target_ok;
        cmd.to_aux = (sub == SUB_AUX);
        if (sub == SUB_AUX)
        begin
            cmd.chan  = 3'd0;
            cmd.level = aux_lvl;
        end
        else if (sub == SUB_NINE)
        begin
            cmd.chan  = CHAN_NINE;
            cmd.level = drv_lvl;
        end
        else
        begin
            cmd.chan  = CHAN_TOP - sub[2:0];
            cmd.level = drv_lvl;
        end
    end

endmodule

>>> hw/rtl/led_command_line_decoder_core.sv
// led command line decoder: text bytes in, one led command per valid line out
// depends on lcld_pkg and lcld_line
//
// input channel: in_valid / in_stall with rx_byte, one text byte per transfer.
// carriage return is skipped; newline or a zero byte ends the line.
// output channel: out_valid / out_stall with to_aux_led, driver_channel and
// level; at most one transfer per line, caused by the line-end byte.
// the command appears on the output in the cycle after the line-end
// byte is accepted. throughput: one byte per cycle while not stalled, since the line
// state and the output register both update in the cycle a byte is accepted.
// when the receiver stalls, the pending command is held in the output
// register and in_stall rises until it is taken; with the output register
// empty or draining, bytes keep flowing every cycle.
// reset clears the line state and empties the output register; bytes of a
// partly received line are discarded.

module led_command_line_decoder_core #(
    parameter int LINE_MAX = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    rx_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          to_aux_led,
    output logic [2:0]                    driver_channel,
    output logic [lcld_pkg::LEVEL_W-1:0]  level
);
    import lcld_pkg::*;

    logic               in_fire;
    logic               hold;
    cmd_t               cmd;
    logic               out_valid_reg, out_valid_next;
    logic               to_aux_reg;
    logic [2:0]         chan_reg;
    logic [LEVEL_W-1:0] level_reg;

    assign hold     = out_valid_reg && out_stall;
    assign in_stall = hold;
    assign in_fire  = in_valid && !in_stall;

    lcld_line #(
        .LINE_MAX (LINE_MAX)
    ) u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (in_fire),
        .rx_byte (rx_byte),
        .cmd     (cmd)
    );

    assign out_valid_next = cmd.valid ? 1'b1 : hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid)
        begin
            to_aux_reg <= cmd.to_aux;
            chan_reg   <= cmd.chan;
            level_reg  <= cmd.level;
        end
    end

    assign out_valid      = out_valid_reg;
    assign to_aux_led     = to_aux_reg;
    assign driver_channel = chan_reg;
    assign level          = level_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !to_aux_led |-> level[0] == 1'b0 || level == DRIVER_MAX)
        else $error("driver level must be even or saturated");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && to_aux_led |-> level <= AUX_MAX[LEVEL_W-1:0] && driver_channel == 3'd0)
        else $error("aux command out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && rx_byte != CH_NUL && rx_byte != CH_LF
        |=> !out_valid || $past(out_valid && out_stall))
        else $error("command produced without line end");

endmodule

>>> tb/led_command_checker.sv
`timescale 1ns / 1ps
// checker for the led command line decoder: predicts commands from accepted bytes
// and compares every output transfer; depends on lcld_pkg

module led_command_checker #(
    parameter int LINE_MAX = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [7:0]                   rx_byte,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic                         to_aux_led,
    input  logic [2:0]                   driver_channel,
    input  logic [lcld_pkg::LEVEL_W-1:0] level,
    input  logic                         done,
    output int                           fail_count,
    output int                           pending
);
    import lcld_pkg::*;

    localparam int LED_AUX = 16;

    typedef struct packed {
        logic               aux;
        logic [2:0]         chan;
        logic [LEVEL_W-1:0] lvl;
    } led_cmd_t;

    logic [$clog2(LINE_MAX)-1:0] chars_kept;
    logic [7:0]                  tgt_char;
    logic [7:0]                  sub_char;
    logic [1:0]                  num_phase;
    logic                        num_neg;
    logic [MAG_W-1:0]            num_mag;

    led_cmd_t expected_cmds[$];
    led_cmd_t want;
    int       fail_total = 0;
    bit       done_seen = 0;

    task report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_total++;
    endtask

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic [MAG_W-1:0] push_digit(logic [MAG_W-1:0] mag, logic [7:0] c);
        int unsigned d;
        d = c - CH_ZERO;
        if (mag > (MAG_MAX - d) / 10)
            return MAG_MAX;
        return MAG_W'(mag * 10 + d);
    endfunction

    task clear_line();
        chars_kept = '0;
        tgt_char   = '0;
        sub_char   = '0;
        num_phase  = PH_BEFORE;
        num_neg    = 1'b0;
        num_mag    = '0;
    endtask

    task feed_number(input logic [7:0] b);
        case (num_phase)
            PH_BEFORE:
            begin
                if (!(b == CH_SP || b == CH_TAB || b == CH_VT || b == CH_FF))
                begin
                    if (b == CH_PLUS)
                        num_phase = PH_NUMBER;
                    else if (b == CH_MINUS)
                    begin
                        num_neg   = 1'b1;
                        num_phase = PH_NUMBER;
                    end
                    else if (is_digit(b))
                    begin
                        num_mag   = push_digit(num_mag, b);
                        num_phase = PH_NUMBER;
                    end
                    else
                        num_phase = PH_DONE;
                end
            end
            PH_NUMBER:
            begin
                if (is_digit(b))
                    num_mag = push_digit(num_mag, b);
                else
                    num_phase = PH_DONE;
            end
            default: ;
        endcase
    endtask

    function automatic bit line_command(output led_cmd_t cmd);
        int unsigned sub;
        int unsigned led;
        int unsigned val;
        cmd = '0;
        if (chars_kept < 3 || !is_digit(sub_char))
            return 0;
        sub = sub_char - CH_ZERO;
        if (tgt_char == CH_EIGHT)
            led = (sub == SUB_AUX) ? LED_AUX : sub;
        else if (tgt_char == CH_NINE)
            led = sub + 8;
        else
            return 0;
        val = num_neg ? 0 : num_mag;
        if (led == LED_AUX)
        begin
            cmd.aux = 1'b1;
            cmd.lvl = LEVEL_W'((val > AUX_MAX) ? AUX_MAX : val);
            return 1;
        end
        if (led < 8)
            cmd.chan = 3'(CHAN_TOP - led);
        else if (led <= 15)
            cmd.chan = 3'(15 - led);
        else
            return 0;
        val = val * 2;
        cmd.lvl = LEVEL_W'((val > DRIVER_MAX) ? DRIVER_MAX : val);
        return 1;
    endfunction

    task take_byte(input logic [7:0] b);
        led_cmd_t cmd;
        if (b == CH_NUL || b == CH_LF)
        begin
            if (line_command(cmd))
                expected_cmds.push_back(cmd);
            clear_line();
        end
        else if (b != CH_CR && chars_kept < LINE_MAX - 1)
        begin
            if (chars_kept == 0)
                tgt_char = b;
            else if (chars_kept == 1)
                sub_char = b;
            else if (chars_kept >= 3)
                feed_number(b);
            chars_kept++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_line();
            expected_cmds.delete();
            pending    <= 0;
            fail_count <= fail_total;
        end
        else
        begin
            // output first: a command never leaves in the cycle its line ends
            if (out_valid && !out_stall)
            begin
                if (expected_cmds.size() == 0)
                    report_mismatch("output transfer with no command expected");
                else
                begin
                    want = expected_cmds.pop_front();
                    if (to_aux_led !== want.aux)
                        report_mismatch($sformatf("to_aux_led expected %0d got %0d",
                                                  want.aux, to_aux_led));
                    if (driver_channel !== want.chan)
                        report_mismatch($sformatf("driver_channel expected %0d got %0d",
                                                  want.chan, driver_channel));
                    if (level !== want.lvl)
                        report_mismatch($sformatf("level expected %0d got %0d",
                                                  want.lvl, level));
                end
            end
            if (in_valid && !in_stall)
                take_byte(rx_byte);
            if (done && !done_seen)
            begin
                done_seen = 1;
                if (expected_cmds.size() != 0)
                    report_mismatch($sformatf("%0d commands never arrived",
                                              expected_cmds.size()));
            end
            pending    <= expected_cmds.size();
            fail_count <= fail_total;
        end
    end

endmodule

>>> tb/tb_led_command_line_decoder_core.sv
`timescale 1ns / 1ps
// top of the led command line decoder testbench: clock, reset, byte stimulus,
// random output stall and verdict; depends on lcld_pkg, the core and led_command_checker

module tb_led_command_line_decoder_core;
    import lcld_pkg::*;

    localparam int ITEM_TARGET = 1750;
    localparam int QUIET_FROM  = 1600;
    localparam int CYCLE_LIMIT = 200000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic [7:0]         rx_byte = 8'h00;
    logic               out_stall = 1'b0;
    logic               done = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic               to_aux_led;
    logic [2:0]         driver_channel;
    logic [LEVEL_W-1:0] level;
    int                 fail_count;
    int                 pending;

    int         cycles = 0;
    int         bytes_sent = 0;
    int         idle_pct = 25;
    int         stall_left = 0;
    bit         quiet = 0;
    logic [7:0] line_bytes[$];

    led_command_line_decoder_core #(.LINE_MAX(10)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .to_aux_led     (to_aux_led),
        .driver_channel (driver_channel),
        .level          (level)
    );

    led_command_checker #(.LINE_MAX(10)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .to_aux_led     (to_aux_led),
        .driver_channel (driver_channel),
        .level          (level),
        .done           (done),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stall in short bursts
    always @(posedge clk)
    begin
        if (quiet || idle_pct == 0)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(99) < idle_pct)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(2);
        end
        else
            out_stall <= 1'b0;
    end

    task send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        if (b != CH_CR)
            bytes_sent++;
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task drain_commands();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task build_line();
        logic [7:0] tgt;
        logic [7:0] sub;
        line_bytes.delete();
        if ($urandom_range(99) < 80)
        begin
            if ($urandom_range(9) == 0)
                tgt = 8'($urandom_range(255));
            else
                tgt = $urandom_range(1) ? CH_EIGHT : CH_NINE;
            if ($urandom_range(9) == 0)
                sub = 8'($urandom_range(255));
            else
                sub = 8'(CH_ZERO + $urandom_range(9));
            line_bytes.push_back(tgt);
            line_bytes.push_back(sub);
            line_bytes.push_back(8'($urandom_range(32, 126)));
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 3))
                    case ($urandom_range(3))
                        0: line_bytes.push_back(CH_SP);
                        1: line_bytes.push_back(CH_TAB);
                        2: line_bytes.push_back(CH_VT);
                        default: line_bytes.push_back(CH_FF);
                    endcase
            case ($urandom_range(9))
                0: line_bytes.push_back(CH_PLUS);
                1: line_bytes.push_back(CH_MINUS);
                default: ;
            endcase
            repeat ($urandom_range(7))
                line_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
            if ($urandom_range(4) == 0)
                line_bytes.push_back(8'($urandom_range(32, 126)));
            if ($urandom_range(19) == 0)
                line_bytes = line_bytes[0:$urandom_range(1)];
            if ($urandom_range(9) == 0)
                line_bytes.insert($urandom_range(line_bytes.size()), CH_CR);
        end
        else
        begin
            repeat ($urandom_range(12))
                line_bytes.push_back(8'($urandom_range(255)));
        end
        line_bytes.push_back(($urandom_range(3) == 0) ? CH_NUL : CH_LF);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short line, three chars to aux ended by zero byte, out of range channel,
        // whitespace with negative value and carriage return, long line with big value
        send_text("80\n");
        send_text("88 ");
        send_byte(CH_NUL);
        send_text("99 1\n");
        send_text("97\t-3\r\n");
        send_text("89 9999999\n");
        drain_commands();

        while (bytes_sent < ITEM_TARGET)
        begin
            if (bytes_sent >= QUIET_FROM)
                quiet = 1;
            if ($urandom_range(49) == 0)
                idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 40);
            build_line();
            foreach (line_bytes[i])
                send_byte(line_bytes[i]);
            if ($urandom_range(39) == 0)
                drain_commands();
        end

        drain_commands();
        repeat (8) @(posedge clk);
        done <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
